// ===== rtl/plar_pkg.sv =====
`timescale 1ns / 1ps
package plar_pkg;

    localparam int COORD_BITS = 16;
    localparam int TOTAL_BITS = 40;
    localparam int CFG_BITS   = 6;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 8;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         point_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         out_last;
        logic                         points_dropped;
    } t_out_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_pt;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LSQ,
        ST_START,
        ST_STEP,
        ST_RD,
        ST_RDW,
        ST_SEG,
        ST_CHK,
        ST_MULX,
        ST_DXS,
        ST_DXW,
        ST_MULY,
        ST_DYS,
        ST_DYW,
        ST_EMIT,
        ST_FLUSH
    } t_state;

endpackage

// ===== rtl/polyline_arc_length_resampler.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake              | payload
// point in | in        | start & !busy          | i_in (t_in_beat)
// result   | out       | o_strobe, one cycle    | o_out (t_out_beat)
// config   | in        | i_cfg_wr_en            | i_cfg_wr_data (interval count)
//
// a stored point after the first adds its distance from the previous point, found by the bit-serial square root
// a dropped non-final point is not stored and only sets the points_dropped flag
// the final beat starts a walk: one divide for the step, a root per segment
// and two restoring divides for every emitted point
// reset clears stroke state and sets the interval count to 63; no clearing pass
// busy holds new points off; the result receiver cannot stall
module polyline_arc_length_resampler #(
    parameter int MAX_POINTS = plar_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = plar_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  plar_pkg::t_in_beat                i_in,
    output logic                              busy,
    output logic                              o_strobe,
    output plar_pkg::t_out_beat               o_out,
    input  logic                              i_cfg_wr_en,
    input  logic [plar_pkg::CFG_BITS-1:0]     i_cfg_wr_data
);

    localparam int C      = plar_pkg::COORD_BITS;
    localparam int TOT_W  = plar_pkg::TOTAL_BITS;
    localparam int LEN_W  = C + FRAC_BITS + 2;
    localparam int SUM_W  = ((TOT_W > LEN_W) ? TOT_W : LEN_W) + 1;
    localparam int D_W    = SUM_W;
    localparam int PROD_W = C + 1 + LEN_W;
    localparam int NUM_W  = (TOT_W > PROD_W) ? TOT_W : PROD_W;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CB     = plar_pkg::CFG_BITS;

    function automatic logic [C:0] f_absdiff(logic signed [C-1:0] a, logic signed [C-1:0] b);
        logic signed [C:0] d;
        d = (C+1)'(b) - (C+1)'(a);
        return d < 0 ? (C+1)'(-d) : (C+1)'(d);
    endfunction

    function automatic logic [C-1:0] f_interp(logic signed [C-1:0] a, logic signed [C-1:0] b,
                                              logic [C:0] f, logic inx);
        logic signed [C+1:0] base;
        if (b >= a) begin
            base = (C+2)'(a) + $signed({1'b0, f});
            if (inx && base < 0) base = base + (C+2)'(1);
        end else begin
            base = (C+2)'(a) - $signed({1'b0, f});
            if (inx && base > 0) base = base - (C+2)'(1);
        end
        return base[C-1:0];
    endfunction

    plar_pkg::t_state r_state, n_state;

    logic [CB-1:0]      r_cfg, cnt_n;
    logic [CNT_W-1:0]   r_count, r_idx;
    logic [TOT_W-1:0]   r_total, r_step;
    logic               r_ovf, r_last;
    plar_pkg::t_pt      r_prev, r_first, r_a, r_cur, rd_pt;
    logic [LEN_W-1:0]   r_len;
    logic [D_W-1:0]     r_d;
    logic [CB-1:0]      r_emit;
    logic [PROD_W-1:0]  r_prod;
    logic [C-1:0]       r_ox, r_oy, r_px, r_py;

    logic               accept, store_ok, sq_start, sq_done, dv_start, dv_done, dv_inx;
    logic [C:0]         sq_ux, sq_uy, ux, uy;
    logic [LEN_W-1:0]   sq_root;
    logic [NUM_W-1:0]   dv_num, dv_quot;
    logic [LEN_W-1:0]   dv_den;
    logic [SUM_W-1:0]   tot_sum;
    logic [2*C-1:0]     ram_rdata;
    logic [AW-1:0]      ram_addr;
    logic [D_W-1:0]     len_ext;

    assign busy     = r_state != plar_pkg::ST_IDLE;
    assign accept   = start && !busy;
    assign store_ok = r_count < CNT_W'(MAX_POINTS);
    assign cnt_n    = (r_cfg == '0) ? CB'(1) : r_cfg;
    assign rd_pt    = plar_pkg::t_pt'(ram_rdata);
    assign ux       = f_absdiff(r_a.x, r_cur.x);
    assign uy       = f_absdiff(r_a.y, r_cur.y);
    assign tot_sum  = SUM_W'(r_total) + SUM_W'(sq_root);
    assign len_ext  = D_W'(r_len);
    assign ram_addr = busy ? r_idx[AW-1:0] : r_count[AW-1:0];

    always_comb begin
        if (busy) begin
            sq_ux = f_absdiff(r_a.x, rd_pt.x);
            sq_uy = f_absdiff(r_a.y, rd_pt.y);
        end else begin
            sq_ux = f_absdiff(r_prev.x, i_in.point_x);
            sq_uy = f_absdiff(r_prev.y, i_in.point_y);
        end
    end

    plar_ram #(.WIDTH(2 * C), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && store_ok),
        .i_addr  (ram_addr),
        .i_wdata ({i_in.point_x, i_in.point_y}),
        .o_rdata (ram_rdata)
    );

    plar_sqrt #(.IN_W(C + 1), .FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_ux    (sq_ux),
        .i_uy    (sq_uy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    plar_div #(.NUM_W(NUM_W), .DEN_W(LEN_W)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (dv_start),
        .i_num     (dv_num),
        .i_den     (dv_den),
        .o_done    (dv_done),
        .o_quot    (dv_quot),
        .o_inexact (dv_inx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plar_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        sq_start = 1'b0;
        dv_start = 1'b0;
        dv_num   = NUM_W'(r_prod);
        dv_den   = r_len;
        unique case (r_state)
            plar_pkg::ST_IDLE: begin
                if (accept) begin
                    if (store_ok && r_count != '0) begin
                        sq_start = 1'b1;
                        n_state  = plar_pkg::ST_LSQ;
                    end else if (i_in.point_last) begin
                        n_state = plar_pkg::ST_START;
                    end
                end
            end
            plar_pkg::ST_LSQ: begin
                if (sq_done) n_state = r_last ? plar_pkg::ST_START : plar_pkg::ST_IDLE;
            end
            plar_pkg::ST_START: begin
                if (r_total == '0) begin
                    n_state = plar_pkg::ST_FLUSH;
                end else begin
                    dv_start = 1'b1;
                    dv_num   = NUM_W'(r_total);
                    dv_den   = LEN_W'(cnt_n);
                    n_state  = plar_pkg::ST_STEP;
                end
            end
            plar_pkg::ST_STEP: begin
                if (dv_done) n_state = (r_count > CNT_W'(1)) ? plar_pkg::ST_RD
                                                             : plar_pkg::ST_FLUSH;
            end
            plar_pkg::ST_RD:  n_state = plar_pkg::ST_RDW;
            plar_pkg::ST_RDW: begin
                sq_start = 1'b1;
                n_state  = plar_pkg::ST_SEG;
            end
            plar_pkg::ST_SEG: begin
                if (sq_done) n_state = plar_pkg::ST_CHK;
            end
            plar_pkg::ST_CHK: begin
                priority if (r_emit == cnt_n) begin
                    n_state = plar_pkg::ST_FLUSH;
                end else if (r_d <= len_ext) begin
                    n_state = plar_pkg::ST_MULX;
                end else if (CNT_W'(r_idx + 1'b1) == r_count) begin
                    n_state = plar_pkg::ST_FLUSH;
                end else begin
                    n_state = plar_pkg::ST_RD;
                end
            end
            plar_pkg::ST_MULX: n_state = plar_pkg::ST_DXS;
            plar_pkg::ST_DXS: begin
                dv_start = 1'b1;
                n_state  = plar_pkg::ST_DXW;
            end
            plar_pkg::ST_DXW: begin
                if (dv_done) n_state = plar_pkg::ST_MULY;
            end
            plar_pkg::ST_MULY: n_state = plar_pkg::ST_DYS;
            plar_pkg::ST_DYS: begin
                dv_start = 1'b1;
                n_state  = plar_pkg::ST_DYW;
            end
            plar_pkg::ST_DYW: begin
                if (dv_done) n_state = plar_pkg::ST_EMIT;
            end
            plar_pkg::ST_EMIT:  n_state = plar_pkg::ST_CHK;
            plar_pkg::ST_FLUSH: n_state = plar_pkg::ST_IDLE;
            default:            n_state = plar_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CB'(63);
            r_count  <= '0;
            r_total  <= '0;
            r_ovf    <= 1'b0;
            r_last   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_wr_en) r_cfg <= i_cfg_wr_data;
            unique case (r_state)
                plar_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_last <= i_in.point_last;
                        if (store_ok) begin
                            r_prev  <= '{x: i_in.point_x, y: i_in.point_y};
                            r_count <= r_count + 1'b1;
                            if (r_count == '0) r_first <= '{x: i_in.point_x, y: i_in.point_y};
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                plar_pkg::ST_LSQ: begin
                    if (sq_done) begin
                        r_total <= (tot_sum > SUM_W'({TOT_W{1'b1}})) ? {TOT_W{1'b1}}
                                                                   : tot_sum[TOT_W-1:0];
                    end
                end
                plar_pkg::ST_START: begin
                    r_px <= r_first.x;
                    r_py <= r_first.y;
                    r_a  <= r_first;
                end
                plar_pkg::ST_STEP: begin
                    if (dv_done) begin
                        r_step <= (dv_quot == '0) ? TOT_W'(1) : dv_quot[TOT_W-1:0];
                        r_d    <= (dv_quot == '0) ? D_W'(1) : D_W'(dv_quot[TOT_W-1:0]);
                        r_idx  <= CNT_W'(1);
                        r_emit <= '0;
                    end
                end
                plar_pkg::ST_RDW: r_cur <= rd_pt;
                plar_pkg::ST_SEG: begin
                    if (sq_done) r_len <= sq_root;
                end
                plar_pkg::ST_CHK: begin
                    if (r_emit != cnt_n && !(r_d <= len_ext)) begin
                        r_d   <= r_d - len_ext;
                        r_a   <= r_cur;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                plar_pkg::ST_MULX: r_prod <= ux * r_d[LEN_W-1:0];
                plar_pkg::ST_DXW: begin
                    if (dv_done) r_ox <= f_interp(r_a.x, r_cur.x, dv_quot[C:0], dv_inx);
                end
                plar_pkg::ST_MULY: r_prod <= uy * r_d[LEN_W-1:0];
                plar_pkg::ST_DYW: begin
                    if (dv_done) r_oy <= f_interp(r_a.y, r_cur.y, dv_quot[C:0], dv_inx);
                end
                plar_pkg::ST_EMIT: begin
                    o_strobe <= 1'b1;
                    o_out    <= '{out_x: r_px, out_y: r_py, out_last: 1'b0,
                                  points_dropped: r_ovf};
                    r_px     <= r_ox;
                    r_py     <= r_oy;
                    r_emit   <= r_emit + 1'b1;
                    r_d      <= r_d + D_W'(r_step);
                end
                plar_pkg::ST_FLUSH: begin
                    o_strobe <= 1'b1;
                    o_out    <= '{out_x: r_px, out_y: r_py, out_last: 1'b1,
                                  points_dropped: r_ovf};
                    r_count  <= '0;
                    r_total  <= '0;
                    r_ovf    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/plar_ram.sv =====
`timescale 1ns / 1ps
module plar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/plar_sqrt.sv =====
`timescale 1ns / 1ps
module plar_sqrt #(
    parameter int IN_W      = 17,
    parameter int FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [IN_W-1:0]             i_ux,
    input  logic [IN_W-1:0]             i_uy,
    output logic                        o_done,
    output logic [IN_W+FRAC_BITS:0]     o_root
);

    localparam int ITER  = IN_W + FRAC_BITS + 1;
    localparam int RAD_W = 2 * ITER;
    localparam int SUM_W = 2 * IN_W + 1;
    localparam int CW    = $clog2(ITER + 1);

    logic [2*IN_W-1:0] r_sx, r_sy;
    logic              r_load, r_run;
    logic [CW-1:0]     r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ITER+1:0]   r_rem;
    logic [ITER-1:0]   r_root;
    logic [SUM_W-1:0]  sum;
    logic [ITER+1:0]   rem_sh, trial;

    assign sum    = {1'b0, r_sx} + {1'b0, r_sy};
    assign rem_sh = {r_rem[ITER-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_run  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            r_load <= i_start;
            if (i_start) begin
                r_sx <= i_ux * i_ux;
                r_sy <= i_uy * i_uy;
            end
            if (r_load) begin
                r_rad  <= RAD_W'(sum) << (2 * FRAC_BITS);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[ITER-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[ITER-2:0], 1'b0};
                end
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ITER - 1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/plar_div.sv =====
`timescale 1ns / 1ps
module plar_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic             o_inexact
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_run;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   rem_sh, rem_sub;
    logic             ge;

    assign rem_sh    = {r_rem, r_num[NUM_W-1]};
    assign ge        = rem_sh >= {1'b0, r_den};
    assign rem_sub   = rem_sh - {1'b0, r_den};
    assign o_inexact = r_rem != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                o_quot <= {o_quot[NUM_W-2:0], ge};
                r_num  <= r_num << 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule
